[rtl/bfe_pkg.sv]
// Shared types, codes and helpers of the BPDU field extractor.
package bfe_pkg;

    localparam int MAX_MSTI_DEF  = 64;
    localparam int MAX_FRAME_DEF = 1500;
    localparam int QUEUE_DEPTH   = 4;
    localparam int LEN_W         = 11;
    localparam int NSLOT         = 3;

    localparam logic [LEN_W-1:0] BODY_LEN    = 11'd35;
    localparam logic [LEN_W-1:0] MST_MIN_LEN = 11'd102;

    // BPDU type codes
    localparam logic [7:0] TYPE_CONFIG = 8'h00;
    localparam logic [7:0] TYPE_RST    = 8'h02;
    localparam logic [7:0] TYPE_TCN    = 8'h80;

    // running verdict of a frame
    typedef enum logic [3:0] {
        CLS_NOT_STP   = 4'd0,
        CLS_TCN       = 4'd1,
        CLS_SPB       = 4'd2,
        CLS_TRUNC     = 4'd3,
        CLS_CONFIG    = 4'd4,
        CLS_RST       = 4'd5,
        CLS_RST_SHORT = 4'd6,
        CLS_MSTP      = 4'd7,
        CLS_V3ZERO    = 4'd8,
        CLS_ALT       = 4'd9
    } t_class;

    // field tags, in wire order
    localparam logic [5:0] TAG_VERDICT    = 6'd0;
    localparam logic [5:0] TAG_VERSION    = 6'd1;
    localparam logic [5:0] TAG_TYPE       = 6'd2;
    localparam logic [5:0] TAG_FLAGS      = 6'd3;
    localparam logic [5:0] TAG_ROOT_PRI   = 6'd4;
    localparam logic [5:0] TAG_ROOT_EXT   = 6'd5;
    localparam logic [5:0] TAG_ROOT_MAC   = 6'd6;
    localparam logic [5:0] TAG_ROOT_COST  = 6'd7;
    localparam logic [5:0] TAG_BR_PRI     = 6'd8;
    localparam logic [5:0] TAG_BR_EXT     = 6'd9;
    localparam logic [5:0] TAG_BR_MAC     = 6'd10;
    localparam logic [5:0] TAG_PORT_PRI   = 6'd11;
    localparam logic [5:0] TAG_PORT_NUM   = 6'd12;
    localparam logic [5:0] TAG_MSG_AGE    = 6'd13;
    localparam logic [5:0] TAG_MAX_AGE    = 6'd14;
    localparam logic [5:0] TAG_HELLO      = 6'd15;
    localparam logic [5:0] TAG_FWD_DELAY  = 6'd16;
    localparam logic [5:0] TAG_V1_LEN     = 6'd17;
    localparam logic [5:0] TAG_V3_LEN     = 6'd18;
    localparam logic [5:0] TAG_FMT_SEL    = 6'd19;
    localparam logic [5:0] TAG_REVISION   = 6'd20;
    localparam logic [5:0] TAG_CIST_COST  = 6'd21;
    localparam logic [5:0] TAG_CIST_PRI   = 6'd22;
    localparam logic [5:0] TAG_CIST_EXT   = 6'd23;
    localparam logic [5:0] TAG_CIST_MAC   = 6'd24;
    localparam logic [5:0] TAG_CIST_HOPS  = 6'd25;
    localparam logic [5:0] TAG_MSTI_FLAGS = 6'd26;
    localparam logic [5:0] TAG_MSTI_PRI   = 6'd27;
    localparam logic [5:0] TAG_MSTI_ID    = 6'd28;
    localparam logic [5:0] TAG_MSTI_MAC   = 6'd29;
    localparam logic [5:0] TAG_MSTI_COST  = 6'd30;
    localparam logic [5:0] TAG_MSTI_BPRI  = 6'd31;
    localparam logic [5:0] TAG_MSTI_PPRI  = 6'd32;
    localparam logic [5:0] TAG_MSTI_HOPS  = 6'd33;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] frame_length;
        logic             start_of_frame;
    } t_item;

    typedef struct packed {
        logic [5:0]  field_tag;
        logic [5:0]  msti_index;
        logic [47:0] field_value;
        logic        end_of_frame;
    } t_rec;

    // records caused by one byte, slots 0 .. cnt-1 in order
    typedef struct packed {
        logic [1:0]           cnt;
        t_rec [NSLOT-1:0]     rec;
    } t_bundle;

    function automatic t_rec mk_rec(logic [5:0] tag, logic [5:0] idx, logic [47:0] val,
                                    logic eof);
        t_rec r;
        r.field_tag    = tag;
        r.msti_index   = idx;
        r.field_value  = val;
        r.end_of_frame = eof;
        return r;
    endfunction

endpackage

[rtl/bfe_front.sv]
// Front end: byte parser that classifies the frame and builds the records of each byte.
module bfe_front #(
    parameter int MAX_MSTI  = bfe_pkg::MAX_MSTI_DEF,
    parameter int MAX_FRAME = bfe_pkg::MAX_FRAME_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  bfe_pkg::t_item  i_item,
    output logic            o_wr,
    output bfe_pkg::t_bundle o_bundle
);
    import bfe_pkg::*;

    localparam logic [LEN_W-1:0] L_MAX  = LEN_W'(MAX_FRAME);
    localparam logic [6:0]       M_MAX  = 7'(MAX_MSTI);

    logic [LEN_W-1:0] r_pos, n_pos;
    logic [47:0]      r_acc, n_acc;
    logic [7:0]       r_pv, n_pv;
    logic [15:0]      r_v3, n_v3;
    logic [6:0]       r_msti, n_msti;
    t_class           r_cls, n_cls;

    logic [LEN_W-1:0] s_pos, len, q;
    logic [47:0]      s_acc, a;
    logic [7:0]       b;
    logic [15:0]      w;
    logic             sof, live, ok, v_en;
    logic [1:0]       nf;
    t_rec             f0, f1;
    logic [16:0]      total, avail;
    logic [12:0]      whole;
    logic [5:0]       m;

    assign sof  = i_item.start_of_frame;
    assign b    = i_item.data_byte;
    assign len  = (i_item.frame_length > L_MAX) ? L_MAX : i_item.frame_length;
    assign s_pos = sof ? '0 : r_pos;
    assign s_acc = sof ? '0 : r_acc;
    assign live = s_pos < len;
    assign a    = {s_acc[39:0], b};
    assign w    = a[15:0];
    assign q    = s_pos - MST_MIN_LEN;
    assign m    = q[9:4];

    // MSTI count from version 3 length, clipped to bytes present
    always_comb begin
        total = (r_v3 >= 16'd64) ? {1'b0, r_v3 - 16'd64} : {1'b0, r_v3[11:0], 4'd0};
        avail = (len >= MST_MIN_LEN) ? 17'(len - MST_MIN_LEN) : '0;
        if (total > avail) total = avail;
        whole = total[16:4];
    end

    // field decode and state update
    always_comb begin
        n_pos  = s_pos;
        n_acc  = s_acc;
        n_pv   = sof ? '0 : r_pv;
        n_v3   = sof ? '0 : r_v3;
        n_msti = sof ? '0 : r_msti;
        n_cls  = sof ? CLS_NOT_STP : r_cls;
        nf     = 2'd0;
        f0     = mk_rec(TAG_VERDICT, 6'd0, 48'd0, 1'b0);
        f1     = f0;
        ok     = 1'b0;
        if (live) begin
            n_acc = a;
            if (s_pos != 11'h7FF) n_pos = s_pos + 1'b1;
            if (s_pos == 11'd2) begin
                n_pv = b;
            end else if (s_pos == 11'd3) begin
                ok = (a[31:16] == 16'd0) &&
                     (b == TYPE_CONFIG || b == TYPE_RST || b == TYPE_TCN) &&
                     (b == TYPE_TCN || n_pv == 8'd0 || n_pv == 8'd2 ||
                      n_pv == 8'd3 || n_pv == 8'd4);
                if (ok) begin
                    if (b == TYPE_TCN)          n_cls = CLS_TCN;
                    else if (n_pv == 8'd4)      n_cls = CLS_SPB;
                    else if (len < BODY_LEN)    n_cls = CLS_TRUNC;
                    else if (b == TYPE_CONFIG)  n_cls = CLS_CONFIG;
                    else if (len == BODY_LEN)   n_cls = CLS_RST_SHORT;
                    else                        n_cls = CLS_RST;
                    f0 = mk_rec(TAG_VERSION, 6'd0, {40'd0, n_pv}, 1'b0);
                    f1 = mk_rec(TAG_TYPE, 6'd0, {40'd0, b}, 1'b0);
                    nf = 2'd2;
                end
            end else if (s_pos >= 11'd4 && s_pos < BODY_LEN) begin
                if (n_cls >= CLS_CONFIG) begin
                    nf = 2'd1;
                    case (s_pos)
                        11'd4:  f0 = mk_rec(TAG_FLAGS, 6'd0, {40'd0, b}, 1'b0);
                        11'd6: begin
                            f0 = mk_rec(TAG_ROOT_PRI, 6'd0, {32'd0, w & 16'hF000}, 1'b0);
                            f1 = mk_rec(TAG_ROOT_EXT, 6'd0, {32'd0, w & 16'h0FFF}, 1'b0);
                            nf = 2'd2;
                        end
                        11'd12: f0 = mk_rec(TAG_ROOT_MAC, 6'd0, a, 1'b0);
                        11'd16: f0 = mk_rec(TAG_ROOT_COST, 6'd0, {16'd0, a[31:0]}, 1'b0);
                        11'd18: begin
                            f0 = mk_rec(TAG_BR_PRI, 6'd0, {32'd0, w & 16'hF000}, 1'b0);
                            f1 = mk_rec(TAG_BR_EXT, 6'd0, {32'd0, w & 16'h0FFF}, 1'b0);
                            nf = 2'd2;
                        end
                        11'd24: f0 = mk_rec(TAG_BR_MAC, 6'd0, a, 1'b0);
                        11'd26: begin
                            // port priority nibble scaled by 16
                            f0 = mk_rec(TAG_PORT_PRI, 6'd0, {40'd0, w[15:12], 4'd0}, 1'b0);
                            f1 = mk_rec(TAG_PORT_NUM, 6'd0, {32'd0, w & 16'h0FFF}, 1'b0);
                            nf = 2'd2;
                        end
                        11'd28: f0 = mk_rec(TAG_MSG_AGE, 6'd0, {32'd0, w}, 1'b0);
                        11'd30: f0 = mk_rec(TAG_MAX_AGE, 6'd0, {32'd0, w}, 1'b0);
                        11'd32: f0 = mk_rec(TAG_HELLO, 6'd0, {32'd0, w}, 1'b0);
                        11'd34: f0 = mk_rec(TAG_FWD_DELAY, 6'd0, {32'd0, w}, 1'b0);
                        default: nf = 2'd0;
                    endcase
                end
            end else if (s_pos == BODY_LEN) begin
                if (n_cls == CLS_RST) begin
                    f0 = mk_rec(TAG_V1_LEN, 6'd0, {40'd0, b}, 1'b0);
                    nf = 2'd1;
                    if (n_pv >= 8'd3 && b == 8'd0 && len >= MST_MIN_LEN) n_cls = CLS_MSTP;
                end
            end else if (n_cls == CLS_MSTP || n_cls == CLS_V3ZERO || n_cls == CLS_ALT) begin
                if (s_pos == 11'd37 && n_cls == CLS_MSTP) begin
                    n_v3 = w;
                    f0 = mk_rec(TAG_V3_LEN, 6'd0, {32'd0, w}, 1'b0);
                    nf = 2'd1;
                end else if (s_pos == 11'd38 && n_cls == CLS_MSTP) begin
                    f0 = mk_rec(TAG_FMT_SEL, 6'd0, {40'd0, b}, 1'b0);
                    nf = 2'd1;
                    if (r_v3 == 16'd0)
                        n_cls = (len == {3'd0, b} + 11'd39) ? CLS_ALT : CLS_V3ZERO;
                    else
                        n_msti = (whole > 13'(M_MAX)) ? M_MAX : whole[6:0];
                end else if (s_pos == 11'd72) begin
                    f0 = mk_rec(TAG_REVISION, 6'd0, {32'd0, w}, 1'b0);
                    nf = 2'd1;
                end else if (n_cls == CLS_MSTP) begin
                    nf = 2'd1;
                    if (s_pos == 11'd92)
                        f0 = mk_rec(TAG_CIST_COST, 6'd0, {16'd0, a[31:0]}, 1'b0);
                    else if (s_pos == 11'd94) begin
                        f0 = mk_rec(TAG_CIST_PRI, 6'd0, {32'd0, w & 16'hF000}, 1'b0);
                        f1 = mk_rec(TAG_CIST_EXT, 6'd0, {32'd0, w & 16'h0FFF}, 1'b0);
                        nf = 2'd2;
                    end else if (s_pos == 11'd100)
                        f0 = mk_rec(TAG_CIST_MAC, 6'd0, a, 1'b0);
                    else if (s_pos == 11'd101)
                        f0 = mk_rec(TAG_CIST_HOPS, 6'd0, {40'd0, b}, 1'b0);
                    else if (s_pos >= MST_MIN_LEN && q < {r_msti, 4'd0}) begin
                        // one MSTI message every 16 bytes
                        case (q[3:0])
                            4'd0:  f0 = mk_rec(TAG_MSTI_FLAGS, m, {40'd0, b}, 1'b0);
                            4'd2: begin
                                f0 = mk_rec(TAG_MSTI_PRI, m, {32'd0, w & 16'hF000}, 1'b0);
                                f1 = mk_rec(TAG_MSTI_ID, m, {32'd0, w & 16'h0FFF}, 1'b0);
                                nf = 2'd2;
                            end
                            4'd8:  f0 = mk_rec(TAG_MSTI_MAC, m, a, 1'b0);
                            4'd12: f0 = mk_rec(TAG_MSTI_COST, m, {16'd0, a[31:0]}, 1'b0);
                            4'd13: f0 = mk_rec(TAG_MSTI_BPRI, m, {44'd0, b[7:4]}, 1'b0);
                            4'd14: f0 = mk_rec(TAG_MSTI_PPRI, m, {44'd0, b[7:4]}, 1'b0);
                            4'd15: f0 = mk_rec(TAG_MSTI_HOPS, m, {40'd0, b}, 1'b0);
                            default: nf = 2'd0;
                        endcase
                    end else
                        nf = 2'd0;
                end
            end
        end
    end

    // pack field records and the verdict into one bundle
    assign v_en = live && (s_pos + 1'b1 == len);
    always_comb begin
        o_bundle.rec[0] = f0;
        o_bundle.rec[1] = f1;
        o_bundle.rec[2] = f1;
        o_bundle.rec[nf] = mk_rec(TAG_VERDICT, 6'd0, {44'd0, n_cls}, 1'b1);
        o_bundle.cnt = nf + {1'b0, v_en};
    end
    assign o_wr = i_accept && (o_bundle.cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_acc  <= '0;
            r_pv   <= '0;
            r_v3   <= '0;
            r_msti <= '0;
            r_cls  <= CLS_NOT_STP;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_acc  <= n_acc;
            r_pv   <= n_pv;
            r_v3   <= n_v3;
            r_msti <= n_msti;
            r_cls  <= n_cls;
        end
    end

endmodule

[rtl/bfe_queue.sv]
// Short bundle queue between the parser and the record serialiser.
module bfe_queue #(
    parameter int DEPTH = bfe_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  bfe_pkg::t_bundle i_data,
    input  logic             i_rd,
    output bfe_pkg::t_bundle o_data,
    output logic             o_full,
    output logic             o_empty
);
    import bfe_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_bundle       mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) mem[r_wp] <= i_data;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr && !o_full)
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_rd && !o_empty)
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + {AW'(0), (i_wr && !o_full)} - {AW'(0), (i_rd && !o_empty)};
        end
    end

endmodule

[rtl/bfe_back.sv]
// Back end: hands out the records of each bundle one request at a time.
module bfe_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  bfe_pkg::t_bundle i_q_data,
    output logic             o_q_rd,
    input  logic             i_pop,
    output logic             o_empty,
    output bfe_pkg::t_rec    o_rec
);
    import bfe_pkg::*;

    t_bundle    r_cur;
    logic [1:0] r_idx;
    logic       r_valid;
    logic       last, take, need;

    assign o_empty = !r_valid;
    assign o_rec   = r_cur.rec[r_idx];
    assign take    = i_pop && r_valid;
    assign last    = (r_idx + 1'b1 == r_cur.cnt);
    assign need    = !r_valid || (take && last);
    assign o_q_rd  = need && !i_q_empty;

    // current bundle and slot pointer
    always_ff @(posedge i_clk) begin
        if (o_q_rd) r_cur <= i_q_data;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (need) begin
            r_valid <= !i_q_empty;
            r_idx   <= '0;
        end else if (take) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // slot pointer stays inside the bundle
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx < r_cur.cnt))
        else $error("slot pointer past bundle");
    // verdict only ever on the last slot of its bundle
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && o_rec.end_of_frame) |-> last)
        else $error("verdict not last in bundle");
    // a request taken mid-bundle leaves the next slot on show
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !last) |=> (r_valid && r_idx == $past(r_idx) + 2'd1))
        else $error("mid-bundle record lost");

endmodule

[rtl/bpdu_field_extractor_unit.sv]
// Top level of the BPDU field extractor: parser front, bundle queue, record back end.
// One payload byte is taken per cycle while full is low; each byte yields up to three
// tag/value records (two field records plus the verdict on the frame's last byte),
// which the back end hands out one per cycle while pop is high. The parser decodes each
// byte combinationally; full rises only when the four-entry bundle queue is full, which
// happens when records are produced faster than they are popped. A record reaches o_result
// once its bundle has been written into the queue and then loaded into the back end.
module bpdu_field_extractor_unit #(
    parameter int MAX_MSTI  = bfe_pkg::MAX_MSTI_DEF,
    parameter int MAX_FRAME = bfe_pkg::MAX_FRAME_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  bfe_pkg::t_item  i_item,
    output logic            empty,
    input  logic            pop,
    output bfe_pkg::t_rec   o_result
);
    import bfe_pkg::*;

    t_bundle wr_bundle, rd_bundle;
    logic    wr, rd, q_empty, accept;

    assign accept = push && !full;

    bfe_front #(.MAX_MSTI(MAX_MSTI), .MAX_FRAME(MAX_FRAME)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_wr     (wr),
        .o_bundle (wr_bundle)
    );

    bfe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_data  (wr_bundle),
        .i_rd    (rd),
        .o_data  (rd_bundle),
        .o_full  (full),
        .o_empty (q_empty)
    );

    bfe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (rd_bundle),
        .o_q_rd    (rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_rec     (o_result)
    );

endmodule
